### sv/psq_pkg.sv
// Package for the positional sequence store.
// Holds the operation codes, result status codes, controller states and the
// command word that the controller broadcasts along the row of cells.
package psq_pkg;

    // Field widths of the operation and result words
    localparam int PSQ_DATA_W  = 32;
    localparam int PSQ_POS_W   = 8;
    localparam int PSQ_COUNT_W = 5;
    // Cell index width, wide enough for up to 128 cells
    localparam int PSQ_IDX_W   = 7;

    typedef enum logic [2:0] {
        MODE_ADD_HEAD  = 3'd0,
        MODE_ADD_TAIL  = 3'd1,
        MODE_DEL_HEAD  = 3'd2,
        MODE_DEL_TAIL  = 3'd3,
        MODE_CLEAR     = 3'd4,
        MODE_INSERT_AT = 3'd5,
        MODE_DELETE_AT = 3'd6,
        MODE_DUMP      = 3'd7
    } t_psq_mode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_psq_status;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } t_psq_state;

    // Per-cycle action of the cell row
    typedef enum logic [1:0] {
        CMD_HOLD = 2'd0,
        CMD_INS  = 2'd1,
        CMD_DEL  = 2'd2,
        CMD_ROT  = 2'd3
    } t_psq_op;

    typedef struct packed {
        t_psq_op              op;
        logic [PSQ_IDX_W-1:0] idx;
    } t_psq_cmd;

endpackage

### sv/psq_if.sv
// Valid/ready channels of the positional sequence store.
// psq_op_if carries operation words, psq_res_if carries result words.
// Depends on nothing.
interface psq_op_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic signed [31:0] data_in;
    logic signed [7:0]  position;

    modport source (output valid, output mode, output data_in, output position, input ready);
    modport sink   (input valid, input mode, input data_in, input position, output ready);
endinterface

interface psq_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [4:0]         count;
    logic signed [31:0] data_out;
    logic               data_valid;
    logic               last;

    modport source (output valid, output status, output count, output data_out,
                    output data_valid, output last, input ready);
    modport sink   (input valid, input status, input count, input data_out,
                    input data_valid, input last, output ready);
endinterface

### sv/psq_cell.sv
// One storage cell of the sequence row.
// Depends on psq_pkg; takes its next value from itself, a neighbor or the load bus.
module psq_cell
    import psq_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                         i_clk,
    input  t_psq_cmd                     i_cmd,
    input  logic signed [PSQ_DATA_W-1:0] i_left,
    input  logic signed [PSQ_DATA_W-1:0] i_right,
    input  logic signed [PSQ_DATA_W-1:0] i_load,
    output logic signed [PSQ_DATA_W-1:0] o_value
);

    localparam logic [PSQ_IDX_W-1:0] MyIdx = PSQ_IDX_W'(IDX);

    logic signed [PSQ_DATA_W-1:0] r_value;
    logic signed [PSQ_DATA_W-1:0] n_value;

    // Pick the next value from the broadcast command and this cell's place
    always_comb begin
        n_value = r_value;
        case (i_cmd.op)
            CMD_INS: begin
                if (MyIdx > i_cmd.idx) begin
                    n_value = i_left;
                end else if (MyIdx == i_cmd.idx) begin
                    n_value = i_load;
                end
            end
            CMD_DEL: begin
                if (MyIdx >= i_cmd.idx) begin
                    n_value = i_right;
                end
            end
            CMD_ROT: begin
                if (MyIdx < i_cmd.idx) begin
                    n_value = i_right;
                end else if (MyIdx == i_cmd.idx) begin
                    n_value = i_load;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

### sv/positional_sequence_store_unit.sv
// Positional sequence store: an ordered list of signed 32-bit values kept in
// a row of CAPACITY shifting cells, head in cell 0.
//
// Usage:
//   i_op  (sink)  : one operation word per handshake: mode, data_in, position.
//   o_res (source): result words: status, count, data_out, data_valid, last.
//   Every edit (add, delete, clear, insert, delete at) updates the row or the count
//   as it is accepted (a rejected add or delete changes neither) and registers one
//   result word, valid in the cycle after acceptance; edits sustain one word per
//   cycle while o_res.ready is high. Dump of a non-empty list loads no word on
//   acceptance, then gives one result word per cycle while o_res.ready is high for
//   each stored value, head first, last marked; the row rotates one place per word
//   and is back in order after the final word. Dump of an empty list gives one word.
//   The output register is the only buffer: while o_res.ready is low the
//   pending word holds, the row holds, and i_op.ready stays low.
//   Reset (i_rst_n low, synchronous) empties the list; cell contents are not
//   cleared, as only cells below the count are ever read.
module positional_sequence_store_unit
    import psq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    psq_op_if.sink   i_op,
    psq_res_if.source o_res
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW + 1 > PSQ_POS_W) ? CW + 1 : PSQ_POS_W;
    localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

    t_psq_state r_state;
    t_psq_state n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_left;
    logic [CW-1:0] n_left;

    logic                         r_out_valid;
    logic [1:0]                   r_status;
    logic [PSQ_COUNT_W-1:0]       r_res_count;
    logic signed [PSQ_DATA_W-1:0] r_data;
    logic                         r_dvalid;
    logic                         r_last;

    logic                         w_out_free;
    logic                         w_accept;
    logic                         w_res_load;
    t_psq_status                  w_status;
    logic signed [PSQ_DATA_W-1:0] w_data;
    logic                         w_dvalid;
    logic                         w_last;
    t_psq_cmd                     w_cmd;
    logic signed [PSQ_DATA_W-1:0] w_load;
    logic signed [PSQ_DATA_W-1:0] w_cell [CAPACITY];

    logic            w_empty;
    logic            w_full;
    logic [CW-1:0]   w_cnt_m1;
    logic            w_pos_pos;
    logic [CMPW-1:0] w_pos_u;
    logic [CMPW-1:0] w_cnt_u;
    logic [CMPW-1:0] w_cnt_m1_u;
    logic [CW-1:0]   w_ins_idx;
    logic [CW-1:0]   w_del_idx;

    // Handshake status
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_accept   = i_op.valid && i_op.ready;

    // Position clamping against the current count
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CapCount);
    assign w_cnt_m1   = r_count - CW'(1);
    assign w_pos_pos  = !i_op.position[PSQ_POS_W-1] && (i_op.position != '0);
    assign w_pos_u    = CMPW'(i_op.position[PSQ_POS_W-2:0]);
    assign w_cnt_u    = CMPW'(r_count);
    assign w_cnt_m1_u = CMPW'(w_cnt_m1);
    assign w_ins_idx  = !w_pos_pos ? '0 :
                        (w_pos_u >= w_cnt_u) ? r_count : w_pos_u[CW-1:0];
    assign w_del_idx  = !w_pos_pos ? '0 :
                        (w_pos_u >= w_cnt_m1_u) ? w_cnt_m1 : w_pos_u[CW-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (t_psq_mode'(i_op.mode) == MODE_DUMP) && !w_empty) begin
                    n_state = S_DUMP;
                end
            end
            S_DUMP: begin
                if (w_out_free && (r_left == CW'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Row command, count update and result word
    always_comb begin
        i_op.ready = 1'b0;
        w_cmd.op   = CMD_HOLD;
        w_cmd.idx  = '0;
        w_load     = i_op.data_in;
        n_count    = r_count;
        n_left     = r_left;
        w_res_load = 1'b0;
        w_status   = ST_DONE;
        w_data     = '0;
        w_dvalid   = 1'b0;
        w_last     = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                i_op.ready = w_out_free;
                if (w_accept) begin
                    w_res_load = 1'b1;
                    unique case (t_psq_mode'(i_op.mode))
                        MODE_ADD_HEAD, MODE_ADD_TAIL, MODE_INSERT_AT: begin
                            if (w_full) begin
                                w_status = ST_FULL;
                            end else begin
                                w_cmd.op = CMD_INS;
                                n_count  = r_count + CW'(1);
                                if (t_psq_mode'(i_op.mode) == MODE_ADD_TAIL) begin
                                    w_cmd.idx = PSQ_IDX_W'(r_count);
                                end else if (t_psq_mode'(i_op.mode) == MODE_INSERT_AT) begin
                                    w_cmd.idx = PSQ_IDX_W'(w_ins_idx);
                                end
                            end
                        end
                        MODE_DEL_HEAD, MODE_DEL_TAIL, MODE_DELETE_AT: begin
                            if (w_empty) begin
                                w_status = ST_EMPTY;
                            end else begin
                                w_cmd.op = CMD_DEL;
                                n_count  = w_cnt_m1;
                                if (t_psq_mode'(i_op.mode) == MODE_DEL_TAIL) begin
                                    w_cmd.idx = PSQ_IDX_W'(w_cnt_m1);
                                end else if (t_psq_mode'(i_op.mode) == MODE_DELETE_AT) begin
                                    w_cmd.idx = PSQ_IDX_W'(w_del_idx);
                                end
                            end
                        end
                        MODE_CLEAR: begin
                            n_count = '0;
                        end
                        MODE_DUMP: begin
                            // Empty list answers at once; otherwise start the walk
                            if (!w_empty) begin
                                w_res_load = 1'b0;
                                n_left     = r_count;
                            end
                        end
                    endcase
                end
            end
            S_DUMP: begin
                // Emit the head and rotate it to the tail of the valid cells
                if (w_out_free) begin
                    w_res_load = 1'b1;
                    w_data     = w_cell[0];
                    w_dvalid   = 1'b1;
                    w_last     = (r_left == CW'(1));
                    w_cmd.op   = CMD_ROT;
                    w_cmd.idx  = PSQ_IDX_W'(w_cnt_m1);
                    w_load     = w_cell[0];
                    n_left     = r_left - CW'(1);
                end
            end
            default: begin
                i_op.ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_status    <= w_status;
            r_res_count <= PSQ_COUNT_W'(n_count);
            r_data      <= w_data;
            r_dvalid    <= w_dvalid;
            r_last      <= w_last;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_status;
    assign o_res.count      = r_res_count;
    assign o_res.data_out   = r_data;
    assign o_res.data_valid = r_dvalid;
    assign o_res.last       = r_last;

    // Row of cells, each wired to its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [PSQ_DATA_W-1:0] w_left;
        logic signed [PSQ_DATA_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = w_load;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_cell[g];
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end

        psq_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .i_load  (w_load),
            .o_value (w_cell[g])
        );
    end

endmodule

### verif/tb_top.sv
// Self-checking bench for positional_sequence_store_unit: directed corner cases, then
// biased random list traffic with random idling, back-pressure and drain pauses.
// Depends on psq_pkg (sv/psq_pkg.sv) and the channel interfaces (sv/psq_if.sv).
module tb_top;
    import psq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP         = 16;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        t_psq_status        status;
        logic [4:0]         count;
        logic signed [31:0] data_out;
        logic               data_valid;
        logic               last;
    } t_res_word;

    typedef enum {
        BIAS_GROW,
        BIAS_SHRINK,
        BIAS_MIXED
    } t_op_bias;

    // Mirror of the list contents plus the result words it still owes
    class list_mirror;
        logic signed [31:0] cells[$];
        t_res_word          due_words[$];
        int errors;
        int n_ops;
        int n_words;
        int n_full;
        int n_empty;
        int n_dumped;

        function void push_edit(t_psq_status st);
            t_res_word r;
            r.status     = st;
            r.count      = 5'(cells.size());
            r.data_out   = '0;
            r.data_valid = 1'b0;
            r.last       = 1'b1;
            due_words.push_back(r);
        endfunction

        // Apply one accepted operation word and queue the words it produces
        function void apply_op(t_psq_mode m, logic signed [31:0] d, logic signed [7:0] p);
            int cnt;
            int idx;
            t_res_word r;
            cnt = cells.size();
            n_ops++;
            case (m)
                MODE_ADD_HEAD, MODE_ADD_TAIL, MODE_INSERT_AT: begin
                    if (m == MODE_ADD_HEAD) idx = 0;
                    else if (m == MODE_ADD_TAIL) idx = cnt;
                    else if (p <= 0) idx = 0;
                    else if (p >= cnt) idx = cnt;
                    else idx = int'(p);
                    if (cnt >= CAP) begin
                        n_full++;
                        push_edit(ST_FULL);
                    end else begin
                        cells.insert(idx, d);
                        push_edit(ST_DONE);
                    end
                end
                MODE_DEL_HEAD, MODE_DEL_TAIL, MODE_DELETE_AT: begin
                    if (cnt == 0) begin
                        n_empty++;
                        push_edit(ST_EMPTY);
                    end else begin
                        if (m == MODE_DEL_HEAD) idx = 0;
                        else if (m == MODE_DEL_TAIL) idx = cnt - 1;
                        else if (p <= 0) idx = 0;
                        else if (p >= cnt - 1) idx = cnt - 1;
                        else idx = int'(p);
                        cells.delete(idx);
                        push_edit(ST_DONE);
                    end
                end
                MODE_CLEAR: begin
                    cells.delete();
                    push_edit(ST_DONE);
                end
                default: begin
                    n_dumped++;
                    if (cnt == 0) begin
                        push_edit(ST_DONE);
                    end else begin
                        for (int i = 0; i < cnt; i++) begin
                            r.status     = ST_DONE;
                            r.count      = 5'(cnt);
                            r.data_out   = cells[i];
                            r.data_valid = 1'b1;
                            r.last       = (i == cnt - 1);
                            due_words.push_back(r);
                        end
                    end
                end
            endcase
        endfunction

        // Compare one accepted result word against the oldest owed word
        function void match_word(t_res_word got);
            t_res_word want;
            n_words++;
            if (due_words.size() == 0) begin
                $error("result word with none expected: status %0d count %0d data %0d",
                       got.status, got.count, got.data_out);
                errors++;
                return;
            end
            want = due_words.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
            if (got.data_out !== want.data_out) begin
                $error("data_out: expected %0d, got %0d", want.data_out, got.data_out);
                errors++;
            end
            if (got.data_valid !== want.data_valid) begin
                $error("data_valid: expected %0b, got %0b", want.data_valid, got.data_valid);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction

        function void flag_leftovers();
            if (due_words.size() != 0) begin
                $error("%0d expected result words never arrived", due_words.size());
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    psq_op_if  op_ch ();
    psq_res_if res_ch ();

    positional_sequence_store_unit #(
        .CAPACITY(CAP)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_op   (op_ch),
        .o_res  (res_ch)
    );

    list_mirror mirror = new();

    int snd_idle_max = 14;
    int rcv_idle_max = 14;
    bit hold_req     = 1'b0;

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Drive all inputs to known values from time zero
    initial begin
        i_rst_n        = 1'b0;
        op_ch.valid    = 1'b0;
        op_ch.mode     = MODE_ADD_HEAD;
        op_ch.data_in  = '0;
        op_ch.position = '0;
        res_ch.ready   = 1'b0;
    end

    // Offer one operation word after a random gap and hold it until accepted
    task automatic send_op(input t_psq_mode m, input logic signed [31:0] d,
                           input logic signed [7:0] p);
        int gap;
        gap = $urandom_range(0, snd_idle_max);
        if (gap > 0) begin
            op_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        op_ch.valid    <= 1'b1;
        op_ch.mode     <= m;
        op_ch.data_in  <= d;
        op_ch.position <= p;
        do @(posedge i_clk); while (!op_ch.ready);
        mirror.apply_op(m, d, p);
    endtask

    // Hold the sender until every owed result word has come back
    task automatic wait_drain();
        while (mirror.due_words.size() != 0) @(posedge i_clk);
    endtask

    // Draw one random operation, weighted by the requested bias
    task automatic send_random(input t_op_bias bias);
        int cnt;
        int r;
        int add_lim;
        int del_lim;
        int dump_lim;
        t_psq_mode m;
        logic signed [31:0] d;
        logic signed [7:0] p;
        cnt = mirror.cells.size();
        r   = $urandom_range(0, 99);
        case (bias)
            BIAS_GROW:   begin add_lim = 72; del_lim = 88; dump_lim = 97; end
            BIAS_SHRINK: begin add_lim = 25; del_lim = 85; dump_lim = 97; end
            default:     begin add_lim = 45; del_lim = 82; dump_lim = 96; end
        endcase
        if (r < add_lim) begin
            case ($urandom_range(0, 2))
                0:       m = MODE_ADD_HEAD;
                1:       m = MODE_ADD_TAIL;
                default: m = MODE_INSERT_AT;
            endcase
        end else if (r < del_lim) begin
            case ($urandom_range(0, 2))
                0:       m = MODE_DEL_HEAD;
                1:       m = MODE_DEL_TAIL;
                default: m = MODE_DELETE_AT;
            endcase
        end else if (r < dump_lim) begin
            m = MODE_DUMP;
        end else begin
            m = MODE_CLEAR;
        end
        // Mostly arbitrary values, now and then an extreme
        case ($urandom_range(0, 11))
            0:       d = 32'sh8000_0000;
            1:       d = 32'sh7FFF_FFFF;
            2:       d = -32'sd1;
            3:       d = '0;
            default: d = $urandom;
        endcase
        // Positions near the live range, sometimes any byte
        if ($urandom_range(0, 3) == 0) p = 8'($urandom_range(0, 255));
        else p = 8'(int'($urandom_range(0, cnt + 4)) - 2);
        send_op(m, d, p);
    endtask

    // Receiver: random stalls per word, with an occasional long hold-off
    initial begin : receiver
        int stall;
        t_res_word got;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = $urandom_range(0, rcv_idle_max);
                if (stall > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            got.status     = t_psq_status'(res_ch.status);
            got.count      = res_ch.count;
            got.data_out   = res_ch.data_out;
            got.data_valid = res_ch.data_valid;
            got.last       = res_ch.last;
            mirror.match_word(got);
        end
    end

    // Main sequence
    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty-list corners
        send_op(MODE_DUMP,      $urandom, 8'($urandom));
        send_op(MODE_DEL_HEAD,  $urandom, 8'($urandom));
        send_op(MODE_DEL_TAIL,  $urandom, 8'($urandom));
        send_op(MODE_DELETE_AT, $urandom, 8'sd0);
        send_op(MODE_CLEAR,     $urandom, 8'($urandom));
        // Extreme values, clamped insert positions
        send_op(MODE_ADD_HEAD,  32'sh8000_0000, 8'sd127);
        send_op(MODE_ADD_TAIL,  32'sh7FFF_FFFF, -8'sd128);
        send_op(MODE_INSERT_AT, -32'sd1,        -8'sd128);
        send_op(MODE_INSERT_AT, 32'sd0,         8'sd127);
        send_op(MODE_INSERT_AT, 32'sh5555_5555, 8'sd2);
        send_op(MODE_INSERT_AT, 32'shAAAA_AAAA, 8'sd1);
        send_op(MODE_DUMP,      $urandom, 8'($urandom));
        // Clamped and exact delete positions
        send_op(MODE_DELETE_AT, $urandom, -8'sd128);
        send_op(MODE_DELETE_AT, $urandom, 8'sd127);
        send_op(MODE_DELETE_AT, $urandom, 8'sd1);
        send_op(MODE_DELETE_AT, $urandom, 8'sd2);
        send_op(MODE_DEL_HEAD,  $urandom, 8'($urandom));
        send_op(MODE_DEL_TAIL,  $urandom, 8'($urandom));
        // Clear of a non-empty list, then a one-value list
        send_op(MODE_ADD_TAIL,  32'sd1, 8'($urandom));
        send_op(MODE_ADD_HEAD,  32'sd2, 8'($urandom));
        send_op(MODE_CLEAR,     $urandom, 8'($urandom));
        send_op(MODE_DUMP,      $urandom, 8'($urandom));
        send_op(MODE_INSERT_AT, $urandom, 8'sd5);
        send_op(MODE_DUMP,      $urandom, 8'($urandom));
        op_ch.valid <= 1'b0;
        wait_drain();

        // Grow toward full with idling on both sides
        repeat (60) send_random(BIAS_GROW);
        op_ch.valid <= 1'b0;
        wait_drain();

        // Back-to-back traffic at full, overflow rejects
        snd_idle_max = 0;
        rcv_idle_max = 0;
        repeat (60) send_random(BIAS_GROW);
        op_ch.valid <= 1'b0;
        wait_drain();

        // Long receiver hold-off while the sender keeps offering
        rcv_idle_max = 14;
        hold_req = 1'b1;
        repeat (60) send_random(BIAS_MIXED);
        op_ch.valid <= 1'b0;
        wait_drain();

        // Shrink to empty, ignored deletes
        snd_idle_max = 14;
        rcv_idle_max = 0;
        repeat (60) send_random(BIAS_SHRINK);
        op_ch.valid <= 1'b0;
        wait_drain();

        // Refill with a steady sender and a stalling receiver
        snd_idle_max = 0;
        rcv_idle_max = 14;
        repeat (70) send_random(BIAS_GROW);
        op_ch.valid <= 1'b0;
        wait_drain();

        // Mixed traffic, random idling, second hold-off
        snd_idle_max = 14;
        hold_req = 1'b1;
        repeat (60) send_random(BIAS_MIXED);
        op_ch.valid <= 1'b0;
        wait_drain();

        // Let any stray word surface before closing out
        repeat (40) @(posedge i_clk);
        mirror.flag_leftovers();

        $display("Covered %0d operations and %0d result words, %0d of them dumps.",
                 mirror.n_ops, mirror.n_words, mirror.n_dumped);
        $display("Saw %0d rejects on a full list and %0d ignored deletes on an empty one.",
                 mirror.n_full, mirror.n_empty);
        if (mirror.errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

### sim.f
sv/psq_pkg.sv
sv/psq_if.sv
sv/psq_cell.sv
sv/positional_sequence_store_unit.sv
verif/tb_top.sv
